/* hw/rtl/omw_pkg.sv */
// Shared widths, constants and types of the three-wheel omni speed mixer.
// No dependencies; every module of the mixer imports it.
package omw_pkg;

	// Field and datapath widths
	localparam int IN_W   = 16;  // vel_x, vel_y, rate_z
	localparam int OUT_W  = 16;  // wheel speeds
	localparam int GAIN_W = 16;  // Q8.8 gain
	localparam int LIM_W  = 15;  // speed limit
	localparam int LIN_W  = 34;  // Q20 linear wheel speed
	localparam int PROD_W = 51;  // linear speed times gain
	localparam int W_W    = 22;  // signed rpm before limiting
	localparam int MAG_W  = 21;  // absolute rpm
	localparam int QW     = 15;  // quotient bits, one divider stage each
	localparam int NUM_W  = MAG_W + LIM_W;
	localparam int NW     = 3;   // wheel count
	localparam int RPM_SH = 28;  // Q20 * Q8.8 down to integer rpm

	// sin(60 deg) in Q0.16
	localparam logic signed [LIN_W-1:0] SIN60 = 34'sd56756;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_GAIN  = 1'b0,
		REG_LIMIT = 1'b1
	} reg_idx_t;

	// Control bits that follow a word down the pipeline
	typedef struct packed {
		logic vld;
		logic scaled;
	} ctrl_t;

	typedef logic [NW-1:0][OUT_W-1:0] wvec_t;

endpackage

/* hw/rtl/omw_kin.sv */
// Kinematics front end: linear wheel speeds, gain multiply, truncation to rpm.
// Three register stages; uses omw_pkg.
module omw_kin (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_vld,
	input  logic signed [omw_pkg::IN_W-1:0]     vel_x,
	input  logic signed [omw_pkg::IN_W-1:0]     vel_y,
	input  logic signed [omw_pkg::IN_W-1:0]     rate_z,
	input  logic        [omw_pkg::GAIN_W-1:0]   gain,
	output logic                                out_vld,
	output logic signed [omw_pkg::W_W-1:0]      w [omw_pkg::NW]
);
	import omw_pkg::*;

	localparam logic signed [PROD_W-1:0] BIAS = PROD_W'((64'd1 << RPM_SH) - 64'd1);

	logic signed [LIN_W-1:0]  xe, ye, ze, zt, xc, yh;
	logic signed [LIN_W-1:0]  lin [NW];
	logic signed [LIN_W-1:0]  lin_s1 [NW];
	logic signed [PROD_W-1:0] prod_s2 [NW];
	logic signed [W_W-1:0]    w_s3 [NW];
	logic                     vld_s1, vld_s2, vld_s3;
	logic signed [GAIN_W:0]   gain_sx;

	// Linear speeds in Q20: 15*z*4096 = z*65536 - z*4096
	always_comb begin
		xe = LIN_W'(vel_x);
		ye = LIN_W'(vel_y);
		ze = LIN_W'(rate_z);
		zt = (ze <<< 16) - (ze <<< 12);
		xc = xe * SIN60;
		yh = ye <<< 15;
		lin[0] = zt - (ye <<< 16);
		lin[1] = zt + yh + xc;
		lin[2] = zt + yh - xc;
	end

	assign gain_sx = $signed({1'b0, gain});

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Per wheel: register linear speed, multiply by gain, truncate toward zero
	for (genvar i = 0; i < NW; i++) begin : g_wheel
		logic signed [PROD_W-1:0] adj;

		assign adj = prod_s2[i] + (prod_s2[i][PROD_W-1] ? BIAS : '0);

		always_ff @(posedge clk) begin
			lin_s1[i]  <= lin[i];
			prod_s2[i] <= PROD_W'(lin_s1[i]) * PROD_W'(gain_sx);
			w_s3[i]    <= adj[RPM_SH+W_W-1:RPM_SH];
		end

		assign w[i] = w_s3[i];
	end

	assign out_vld = vld_s3;

endmodule

/* hw/rtl/omw_norm.sv */
// Limit check: magnitudes, largest magnitude, numerators for proportional scaling.
// Three register stages; uses omw_pkg.
module omw_norm (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_vld,
	input  logic signed [omw_pkg::W_W-1:0]      w [omw_pkg::NW],
	input  logic        [omw_pkg::LIM_W-1:0]    limit,
	output omw_pkg::ctrl_t                      ctrl,
	output logic        [omw_pkg::NUM_W-1:0]    num [omw_pkg::NW],
	output logic        [omw_pkg::MAG_W-1:0]    den,
	output logic        [omw_pkg::NW-1:0]       neg,
	output omw_pkg::wvec_t                      w16
);
	import omw_pkg::*;

	logic [MAG_W-1:0] mag_s4 [NW];
	logic [NW-1:0]    neg_s4, neg_s5, neg_s6;
	wvec_t            w16_s4, w16_s5, w16_s6;
	logic [MAG_W-1:0] mx_s5, mx_s6, m01;
	logic [NUM_W-1:0] num_s5 [NW];
	logic [NUM_W-1:0] num_s6 [NW];
	logic             vld_s4, vld_s5;
	ctrl_t            ctrl_s6;

	// Advance valid and set the scaled flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			ctrl_s6 <= '0;
		end else begin
			vld_s4         <= in_vld;
			vld_s5         <= vld_s4;
			ctrl_s6.vld    <= vld_s5;
			ctrl_s6.scaled <= mx_s5 > MAG_W'(limit);
		end
	end

	// Largest magnitude of the three wheels
	assign m01 = (mag_s4[0] > mag_s4[1]) ? mag_s4[0] : mag_s4[1];

	for (genvar i = 0; i < NW; i++) begin : g_wheel
		logic signed [W_W-1:0] absw;

		assign absw = w[i][W_W-1] ? -w[i] : w[i];

		// Split into sign and magnitude, then form |w| * limit
		always_ff @(posedge clk) begin
			mag_s4[i] <= absw[MAG_W-1:0];
			neg_s4[i] <= w[i][W_W-1];
			w16_s4[i] <= w[i][OUT_W-1:0];
			num_s5[i] <= NUM_W'(mag_s4[i]) * NUM_W'(limit);
			num_s6[i] <= num_s5[i];
		end

		assign num[i] = num_s6[i];
	end

	// Finish the largest magnitude and carry the sideband along
	always_ff @(posedge clk) begin
		mx_s5  <= (m01 > mag_s4[2]) ? m01 : mag_s4[2];
		mx_s6  <= mx_s5;
		neg_s5 <= neg_s4;
		neg_s6 <= neg_s5;
		w16_s5 <= w16_s4;
		w16_s6 <= w16_s5;
	end

	assign ctrl = ctrl_s6;
	assign den  = mx_s6;
	assign neg  = neg_s6;
	assign w16  = w16_s6;

endmodule

/* hw/rtl/omw_div.sv */
// One lane of the pipelined restoring divider, one quotient bit per stage.
// Quotient must fit in QW bits; uses omw_pkg.
module omw_div (
	input  logic                             clk,
	input  logic [omw_pkg::NUM_W-1:0]        num,
	input  logic [omw_pkg::MAG_W-1:0]        den,
	output logic [omw_pkg::QW-1:0]           quo
);
	import omw_pkg::*;

	logic [MAG_W-1:0] rem_s [QW];
	logic [QW-1:0]    nlo_s [QW];
	logic [QW-1:0]    quo_s [QW];
	logic [MAG_W-1:0] den_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [MAG_W-1:0] rem_in, den_in;
		logic [QW-1:0]    nlo_in, quo_in;
		logic [MAG_W:0]   trial, diff;
		logic             ge;

		// Stage zero starts from the upper numerator bits
		if (k == 0) begin : g_first
			assign rem_in = num[NUM_W-1:QW];
			assign nlo_in = num[QW-1:0];
			assign quo_in = '0;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign nlo_in = nlo_s[k-1];
			assign quo_in = quo_s[k-1];
			assign den_in = den_s[k-1];
		end

		// Bring down one bit, subtract when it fits
		assign trial = {rem_in, nlo_in[QW-1]};
		assign diff  = trial - {1'b0, den_in};
		assign ge    = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
			nlo_s[k] <= {nlo_in[QW-2:0], 1'b0};
			quo_s[k] <= {quo_in[QW-2:0], ge};
			den_s[k] <= den_in;
		end
	end

	assign quo = quo_s[QW-1];

endmodule

/* hw/rtl/omni3_wheel_speed_mixer.sv */
// Top level of the three-wheel omni speed mixer: config registers, pipeline, output.
// Instantiates omw_kin, omw_norm and omw_div; uses omw_pkg.
//
// One command word is taken on every cycle that start is high; busy is always low.
// Each command gives one result word, shown for one cycle with
// done high. Its path runs through three kinematics stages, three limit stages,
// fifteen restoring divider stages (one quotient bit each) and the output
// register. Results cannot be held off, so the pipeline never stalls.
// Registers: speed_gain at byte address 0, speed_limit at byte address 4.
module omni3_wheel_speed_mixer (
	input  logic                                clk,
	input  logic                                arst_n,
	// command channel
	input  logic                                start,
	output logic                                busy,
	input  logic signed [omw_pkg::IN_W-1:0]     vel_x,
	input  logic signed [omw_pkg::IN_W-1:0]     vel_y,
	input  logic signed [omw_pkg::IN_W-1:0]     rate_z,
	// result channel
	output logic                                done,
	output logic signed [omw_pkg::OUT_W-1:0]    wheel_one,
	output logic signed [omw_pkg::OUT_W-1:0]    wheel_two,
	output logic signed [omw_pkg::OUT_W-1:0]    wheel_three,
	output logic                                was_scaled,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [2:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import omw_pkg::*;

	logic [GAIN_W-1:0]     gain_q;
	logic [LIM_W-1:0]      limit_q;
	reg_idx_t              reg_idx;
	logic                  wr_en;
	logic                  kin_vld;
	logic signed [W_W-1:0] w [NW];
	ctrl_t                 nctrl;
	logic [NUM_W-1:0]      num [NW];
	logic [MAG_W-1:0]      den;
	logic [NW-1:0]         neg;
	wvec_t                 w16;
	logic [QW-1:0]         quo [NW];
	ctrl_t                 ctrl_s [QW];
	logic [NW-1:0]         neg_s [QW];
	wvec_t                 w16_s [QW];
	wvec_t                 res;

	assign busy   = 1'b0;
	assign pready = 1'b1;

	// Register decode
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign wr_en   = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= GAIN_W'(256);
			limit_q <= LIM_W'(16000);
		end else if (wr_en) begin
			case (reg_idx)
				REG_GAIN:  gain_q  <= pwdata[GAIN_W-1:0];
				REG_LIMIT: limit_q <= pwdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_GAIN:  prdata = 32'(gain_q);
			REG_LIMIT: prdata = 32'(limit_q);
			default:   prdata = '0;
		endcase
	end

	// Kinematics and gain
	omw_kin u_kin (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start),
		.vel_x   (vel_x),
		.vel_y   (vel_y),
		.rate_z  (rate_z),
		.gain    (gain_q),
		.out_vld (kin_vld),
		.w       (w)
	);

	// Limit check and scaling numerators
	omw_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (kin_vld),
		.w      (w),
		.limit  (limit_q),
		.ctrl   (nctrl),
		.num    (num),
		.den    (den),
		.neg    (neg),
		.w16    (w16)
	);

	// One divider lane per wheel
	for (genvar i = 0; i < NW; i++) begin : g_lane
		omw_div u_div (
			.clk (clk),
			.num (num[i]),
			.den (den),
			.quo (quo[i])
		);
	end

	// Delay control and sideband alongside the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QW; k++) begin
				ctrl_s[k] <= '0;
			end
		end else begin
			ctrl_s[0] <= nctrl;
			for (int k = 1; k < QW; k++) begin
				ctrl_s[k] <= ctrl_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		neg_s[0] <= neg;
		w16_s[0] <= w16;
		for (int k = 1; k < QW; k++) begin
			neg_s[k] <= neg_s[k-1];
			w16_s[k] <= w16_s[k-1];
		end
	end

	// Pick scaled quotient with sign restored, or the unscaled speed
	always_comb begin
		for (int i = 0; i < NW; i++) begin
			if (ctrl_s[QW-1].scaled) begin
				res[i] = neg_s[QW-1][i] ? -OUT_W'(quo[i]) : OUT_W'(quo[i]);
			end else begin
				res[i] = w16_s[QW-1][i];
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctrl_s[QW-1].vld;
		end
	end

	always_ff @(posedge clk) begin
		wheel_one   <= res[0];
		wheel_two   <= res[1];
		wheel_three <= res[2];
		was_scaled  <= ctrl_s[QW-1].scaled;
	end

endmodule

/* tb/sv/omw_mix_checker.sv */
`timescale 1ns / 100ps
// Checker for the three-wheel omni speed mixer: mirrors the gain and limit registers
// from the config port, predicts every result word and compares what comes out.
// Depends on omw_pkg for widths, constants and register indexes.
module omw_mix_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             busy,
	input  logic signed [omw_pkg::IN_W-1:0]  vel_x,
	input  logic signed [omw_pkg::IN_W-1:0]  vel_y,
	input  logic signed [omw_pkg::IN_W-1:0]  rate_z,
	input  logic                             done,
	input  logic signed [omw_pkg::OUT_W-1:0] wheel_one,
	input  logic signed [omw_pkg::OUT_W-1:0] wheel_two,
	input  logic signed [omw_pkg::OUT_W-1:0] wheel_three,
	input  logic                             was_scaled,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [2:0]                       paddr,
	input  logic [31:0]                      pwdata,
	input  logic [31:0]                      prdata,
	input  logic                             pready,
	output int                               mismatches,
	output int                               outstanding
);
	import omw_pkg::*;

	typedef struct packed {
		logic signed [OUT_W-1:0] one;
		logic signed [OUT_W-1:0] two;
		logic signed [OUT_W-1:0] three;
		logic                    scaled;
	} wheel_word_t;

	localparam longint ARM_Q12   = 15 * 4096;  // 15 * z, z Q8.8 lifted to Q20
	localparam longint Y_FULL    = 65536;      // y Q12.4 lifted to Q20
	localparam longint Y_HALF    = 32768;      // y/2 in Q20
	localparam longint RPM_DIV   = longint'(1) << RPM_SH;
	localparam logic [GAIN_W-1:0] GAIN_RST = 16'd256;
	localparam logic [LIM_W-1:0]  LIMIT_RST = 15'd16000;

	logic [GAIN_W-1:0] gain_q;
	logic [LIM_W-1:0]  limit_q;
	wheel_word_t       expected_wheels [$];
	wheel_word_t       want;
	int                fail_count = 0;

	assign mismatches = fail_count;

	// Wheel speeds for one command: Q20 linear speeds, gain, then limit scaling
	function automatic wheel_word_t mix_wheels(input logic signed [IN_W-1:0] vx,
			input logic signed [IN_W-1:0] vy, input logic signed [IN_W-1:0] rz,
			input logic [GAIN_W-1:0] gain, input logic [LIM_W-1:0] lim);
		longint      zt;
		longint      peak;
		longint      lin [NW];
		longint      rpm [NW];
		wheel_word_t res;
		int          k;
		zt = longint'(rz) * ARM_Q12;
		lin[0] = zt - longint'(vy) * Y_FULL;
		lin[1] = zt + longint'(vy) * Y_HALF + longint'(vx) * longint'(SIN60);
		lin[2] = zt + longint'(vy) * Y_HALF - longint'(vx) * longint'(SIN60);
		peak = 0;
		for (k = 0; k < NW; k++) begin
			// SV signed division truncates toward zero
			rpm[k] = (lin[k] * longint'(gain)) / RPM_DIV;
			if (rpm[k] > peak)
				peak = rpm[k];
			else if (-rpm[k] > peak)
				peak = -rpm[k];
		end
		res.scaled = peak > longint'(lim);
		if (res.scaled) begin
			for (k = 0; k < NW; k++)
				rpm[k] = (rpm[k] * longint'(lim)) / peak;
		end
		res.one   = rpm[0][OUT_W-1:0];
		res.two   = rpm[1][OUT_W-1:0];
		res.three = rpm[2][OUT_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint exp_val);
		$display("%0t: %s: got %0d, expected %0d", $realtime, what, got, exp_val);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= GAIN_RST;
			limit_q <= LIMIT_RST;
			expected_wheels.delete();
			outstanding <= 0;
		end else begin
			// mirror register writes, check register reads
			if (psel && penable && pready) begin
				case (reg_idx_t'(paddr[2]))
					REG_GAIN: begin
						if (pwrite)
							gain_q <= pwdata[GAIN_W-1:0];
						else if (prdata != 32'(gain_q))
							report_mismatch("speed_gain readback", prdata, gain_q);
					end
					REG_LIMIT: begin
						if (pwrite)
							limit_q <= pwdata[LIM_W-1:0];
						else if (prdata != 32'(limit_q))
							report_mismatch("speed_limit readback", prdata, limit_q);
					end
					default: ;
				endcase
			end
			// predict each accepted command word
			if (start && !busy)
				expected_wheels.push_back(mix_wheels(vel_x, vel_y, rate_z, gain_q, limit_q));
			// compare each result word with the oldest prediction
			if (done) begin
				if (expected_wheels.size() == 0) begin
					report_mismatch("result word with no command pending", wheel_one, 0);
				end else begin
					want = expected_wheels.pop_front();
					if (wheel_one != want.one)
						report_mismatch("wheel_one", wheel_one, want.one);
					if (wheel_two != want.two)
						report_mismatch("wheel_two", wheel_two, want.two);
					if (wheel_three != want.three)
						report_mismatch("wheel_three", wheel_three, want.three);
					if (was_scaled != want.scaled)
						report_mismatch("was_scaled", was_scaled, want.scaled);
				end
			end
			outstanding <= expected_wheels.size();
		end
	end

endmodule

/* tb/sv/omni3_wheel_speed_mixer_tb.sv */
`timescale 1ns / 100ps
// Testbench top of the three-wheel omni speed mixer: clock, reset, command and
// config stimulus, verdict. Depends on omw_pkg, the mixer RTL and omw_mix_checker.
module omni3_wheel_speed_mixer_tb;
	import omw_pkg::*;

	localparam int PHASES     = 7;
	localparam int PHASE_CMDS = 145;
	localparam int DIR_CMDS   = 14;
	localparam int TAIL_WAIT  = 30;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic signed [IN_W-1:0]  vel_x;
	logic signed [IN_W-1:0]  vel_y;
	logic signed [IN_W-1:0]  rate_z;
	logic                    done;
	logic signed [OUT_W-1:0] wheel_one;
	logic signed [OUT_W-1:0] wheel_two;
	logic signed [OUT_W-1:0] wheel_three;
	logic                    was_scaled;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [2:0]              paddr;
	logic [31:0]             pwdata;
	logic [31:0]             prdata;
	logic                    pready;
	int                      mismatches;
	int                      outstanding;

	// Directed commands: field extremes, each axis alone, mixed signs
	logic [IN_W-1:0] dir_x [DIR_CMDS] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
		16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000,
		16'h0000};
	logic [IN_W-1:0] dir_y [DIR_CMDS] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000,
		16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF,
		16'h0000};
	logic [IN_W-1:0] dir_z [DIR_CMDS] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000,
		16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h0000, 16'hFFFF,
		16'h0001};

	omni3_wheel_speed_mixer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.vel_x       (vel_x),
		.vel_y       (vel_y),
		.rate_z      (rate_z),
		.done        (done),
		.wheel_one   (wheel_one),
		.wheel_two   (wheel_two),
		.wheel_three (wheel_three),
		.was_scaled  (was_scaled),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	omw_mix_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.vel_x       (vel_x),
		.vel_y       (vel_y),
		.rate_z      (rate_z),
		.done        (done),
		.wheel_one   (wheel_one),
		.wheel_two   (wheel_two),
		.wheel_three (wheel_three),
		.was_scaled  (was_scaled),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the result stream hangs
	initial begin
		#1000000;
		$display("Mismatches found");
		$finish;
	end

	// Present one command word; start stays high after the accepting edge
	task automatic send_cmd(input logic [IN_W-1:0] vx, input logic [IN_W-1:0] vy,
			input logic [IN_W-1:0] rz);
		start  <= 1'b1;
		vel_x  <= vx;
		vel_y  <= vy;
		rate_z <= rz;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Drop start and hold until every predicted word has come back or the guard runs out
	task automatic drain(input int guard);
		int n;
		n = 0;
		start <= 1'b0;
		do begin
			@(posedge clk);
			n++;
		end while (outstanding != 0 && n < guard);
	endtask

	// Setup and access phases, then idle before the next transfer
	task automatic apb_access(input reg_idx_t idx, input logic wr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Random field: mostly full range, some small, some extremes, some zero
	function automatic logic [IN_W-1:0] pick_field();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return IN_W'($urandom);
			6, 7:             return IN_W'($urandom_range(0, 512) - 256);
			8: begin
				case ($urandom_range(0, 3))
					0:       return 16'h7FFF;
					1:       return 16'h8000;
					2:       return 16'hFFFF;
					default: return 16'h0001;
				endcase
			end
			default:          return '0;
		endcase
	endfunction

	initial begin
		int          ph;
		int          n;
		bit          quiet;
		logic [31:0] gain_word;
		logic [31:0] limit_word;
		arst_n  = 1'b0;
		start   = 1'b0;
		vel_x   = '0;
		vel_y   = '0;
		rate_z  = '0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, then directed commands at the reset setting
		apb_access(REG_GAIN, 1'b0, '0);
		apb_access(REG_LIMIT, 1'b0, '0);
		for (n = 0; n < DIR_CMDS; n++)
			send_cmd(dir_x[n], dir_y[n], dir_z[n]);

		for (ph = 0; ph < PHASES; ph++) begin
			drain(1000);
			case (ph)
				0: begin  // zero gain
					gain_word  = 32'h0000_0000;
					limit_word = 32'd32767;
				end
				1: begin  // top gain, smallest limit
					gain_word  = 32'h0000_FFFF;
					limit_word = 32'd1;
				end
				2: begin  // upper bits dropped: top gain, zero limit
					gain_word  = 32'hFFFF_FFFF;
					limit_word = 32'h0000_8000;
				end
				4: begin
					gain_word  = 32'h0000_1000;
					limit_word = 32'd4000;
				end
				5: begin
					gain_word  = 32'h0000_0001;
					limit_word = 32'd1;
				end
				default: begin
					gain_word  = $urandom;
					limit_word = ($urandom & 32'hFFFF_8000) | $urandom_range(1, 32767);
				end
			endcase
			apb_access(REG_GAIN, 1'b1, gain_word);
			apb_access(REG_LIMIT, 1'b1, limit_word);
			apb_access(REG_GAIN, 1'b0, '0);
			apb_access(REG_LIMIT, 1'b0, '0);

			for (n = 0; n < PHASE_CMDS; n++) begin
				if ($urandom_range(0, 19) == 0)
					send_cmd('0, '0, '0);
				else
					send_cmd(pick_field(), pick_field(), pick_field());
				// idle bursts, with quiet stretches and a quiet last phase
				quiet = (ph == PHASES - 1) || ((n % 50) >= 35);
				if (!quiet && $urandom_range(0, 3) == 0)
					pause($urandom_range(1, 3));
			end
		end

		drain(2000);
		repeat (TAIL_WAIT) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/omw_pkg.sv
hw/rtl/omw_kin.sv
hw/rtl/omw_norm.sv
hw/rtl/omw_div.sv
hw/rtl/omni3_wheel_speed_mixer.sv
tb/sv/omw_mix_checker.sv
tb/sv/omni3_wheel_speed_mixer_tb.sv
